[rtl/tcktg_pkg.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator package
// Shared constants, command types, key decoding and the constant functions
// that build the phase-step and sine tables at elaboration.
// ----------------------------------------------------------------------------
package tcktg_pkg;

    // Default values of the top-level parameters.
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Width of one output sample.
    localparam int OUT_BITS = 16;

    // Command queue between the front and the back.
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_DEPTH    = 2 ** QUEUE_PTR_BITS;

    // Notes per channel.
    localparam int NOTE_BITS  = 3;
    localparam int NOTE_COUNT = 2 ** NOTE_BITS;

    // Sample rate in tenths of a hertz.
    localparam logic [63:0] RATE_TENTHS = 64'd441000;
    // Half pi in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // ASCII codes of the keys that do something.
    localparam logic [7:0] KEY_A    = 8'h61;
    localparam logic [7:0] KEY_S    = 8'h73;
    localparam logic [7:0] KEY_D    = 8'h64;
    localparam logic [7:0] KEY_F    = 8'h66;
    localparam logic [7:0] KEY_Q    = 8'h71;
    localparam logic [7:0] KEY_W    = 8'h77;
    localparam logic [7:0] KEY_E    = 8'h65;
    localparam logic [7:0] KEY_R    = 8'h72;
    localparam logic [7:0] KEY_J    = 8'h6a;
    localparam logic [7:0] KEY_K    = 8'h6b;
    localparam logic [7:0] KEY_L    = 8'h6c;
    localparam logic [7:0] KEY_SEMI = 8'h3b;
    localparam logic [7:0] KEY_U    = 8'h75;
    localparam logic [7:0] KEY_I    = 8'h69;
    localparam logic [7:0] KEY_O    = 8'h6f;
    localparam logic [7:0] KEY_P    = 8'h70;
    localparam logic [7:0] KEY_V    = 8'h76;
    localparam logic [7:0] KEY_N    = 8'h6e;

    // Operations carried from the front to the back.
    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_NOTE_ONE = 3'd1,
        OP_NOTE_TWO = 3'd2,
        OP_MUTE_ONE = 3'd3,
        OP_MUTE_TWO = 3'd4
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [NOTE_BITS-1:0] note;
    } cmd_t;

    typedef struct packed {
        logic hit;
        cmd_t cmd;
    } key_dec_t;

    // Classifies one key code. Codes that change nothing give hit = 0.
    function automatic key_dec_t decode_key(logic [7:0] key);
        key_dec_t d;
        d.hit      = 1'b1;
        d.cmd.op   = OP_NOTE_ONE;
        d.cmd.note = '0;
        case (key)
            KEY_A:    d.cmd.note = 3'd0;
            KEY_S:    d.cmd.note = 3'd1;
            KEY_D:    d.cmd.note = 3'd2;
            KEY_F:    d.cmd.note = 3'd3;
            KEY_Q:    d.cmd.note = 3'd4;
            KEY_W:    d.cmd.note = 3'd5;
            KEY_E:    d.cmd.note = 3'd6;
            KEY_R:    d.cmd.note = 3'd7;
            KEY_J:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd0; end
            KEY_K:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd1; end
            KEY_L:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd2; end
            KEY_SEMI: begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd3; end
            KEY_U:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd4; end
            KEY_I:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd5; end
            KEY_O:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd6; end
            KEY_P:    begin d.cmd.op = OP_NOTE_TWO; d.cmd.note = 3'd7; end
            KEY_V:    d.cmd.op = OP_MUTE_ONE;
            KEY_N:    d.cmd.op = OP_MUTE_TWO;
            default:  d.hit = 1'b0;
        endcase
        return d;
    endfunction

    // Note frequencies in tenths of a hertz, channel one (A3 to A4).
    function automatic logic [15:0] note_tenths_one(logic [NOTE_BITS-1:0] idx);
        logic [15:0] t;
        case (idx)
            3'd0:    t = 16'd2200;
            3'd1:    t = 16'd2469;
            3'd2:    t = 16'd2772;
            3'd3:    t = 16'd2937;
            3'd4:    t = 16'd3296;
            3'd5:    t = 16'd3700;
            3'd6:    t = 16'd4153;
            default: t = 16'd4400;
        endcase
        return t;
    endfunction

    // Note frequencies in tenths of a hertz, channel two (A4 to A5).
    function automatic logic [15:0] note_tenths_two(logic [NOTE_BITS-1:0] idx);
        logic [15:0] t;
        case (idx)
            3'd0:    t = 16'd4400;
            3'd1:    t = 16'd4939;
            3'd2:    t = 16'd5544;
            3'd3:    t = 16'd5873;
            3'd4:    t = 16'd6593;
            3'd5:    t = 16'd7400;
            3'd6:    t = 16'd8306;
            default: t = 16'd8800;
        endcase
        return t;
    endfunction

    // Rounded phase step for a note; evaluated only at elaboration.
    function automatic logic [63:0] note_step(logic [15:0] tenths, int unsigned pbits);
        logic [63:0] num;
        num = (64'(tenths) << pbits) + (RATE_TENTHS >> 1);
        return num / RATE_TENTHS;
    endfunction

    // Quarter-wave sine magnitude at entry j, already scaled to OUT_BITS.
    // The Taylor series runs to x^13 with every term truncated in Q30.
    function automatic logic [OUT_BITS-1:0] sine_mag(int unsigned j, int unsigned abits,
                                                     int unsigned sbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] amp;
        logic [63:0] mag;
        longint      sum;
        x   = (HALF_PI_Q30 * 64'(j) + (64'd1 << (abits - 3))) >> (abits - 2);
        x2  = (x * x) >> 30;
        sum = longint'(x);
        t   = ((x * x2) >> 30) / 64'd6;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd20;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 64'd42;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd72;
        sum = sum + longint'(t);
        t   = ((t * x2) >> 30) / 64'd110;
        sum = sum - longint'(t);
        t   = ((t * x2) >> 30) / 64'd156;
        sum = sum + longint'(t);
        if (sum < 0)
        begin
            sum = 0;
        end
        amp = (64'd1 << (sbits - 1)) - 64'd1;
        mag = (64'(sum) * amp + (64'd1 << 29)) >> 30;
        if (sbits >= OUT_BITS)
        begin
            mag = mag >> (sbits - OUT_BITS);
        end
        else
        begin
            mag = mag << (OUT_BITS - sbits);
        end
        return mag[OUT_BITS-1:0];
    endfunction

endpackage

[rtl/tcktg_if.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator channel interfaces
// Valid/ready channels for key and tick transactions and for stereo samples.
// ----------------------------------------------------------------------------
interface tcktg_key_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] key_code;

    modport source (output valid, output action, output key_code, input ready);
    modport sink   (input valid, input action, input key_code, output ready);
endinterface

interface tcktg_audio_if;
    logic                                valid;
    logic                                ready;
    logic signed [tcktg_pkg::OUT_BITS-1:0] left_sample;
    logic signed [tcktg_pkg::OUT_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

[rtl/tcktg_front.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator front
// Accepts key and tick transactions, drops keys that do nothing and holds
// one classified command for the queue.
// ----------------------------------------------------------------------------
module tcktg_front (
    input  logic              clk,
    input  logic              rst_n,
    tcktg_key_if.sink         keys,
    output logic              push,
    output tcktg_pkg::cmd_t   push_cmd,
    input  logic              q_full
);

    logic                 valid_reg;
    logic                 valid_next;
    tcktg_pkg::cmd_t      cmd_reg;
    tcktg_pkg::cmd_t      cmd_next;
    tcktg_pkg::key_dec_t  dec;
    logic                 accept;

    assign push       = valid_reg && !q_full;
    assign push_cmd   = cmd_reg;
    assign keys.ready = !valid_reg || !q_full;
    assign accept     = keys.valid && keys.ready;

    always_comb
    begin
        dec        = tcktg_pkg::decode_key(keys.key_code);
        valid_next = valid_reg && !push;
        cmd_next   = cmd_reg;
        if (accept)
        begin
            if (keys.action)
            begin
                valid_next    = 1'b1;
                cmd_next.op   = tcktg_pkg::OP_TICK;
                cmd_next.note = '0;
            end
            else
            begin
                valid_next = dec.hit;
                cmd_next   = dec.cmd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

[rtl/tcktg_queue.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator command queue
// A small first-in first-out buffer of commands between front and back.
// ----------------------------------------------------------------------------
module tcktg_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcktg_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output tcktg_pkg::cmd_t   head_cmd
);

    localparam int PB = tcktg_pkg::QUEUE_PTR_BITS;

    tcktg_pkg::cmd_t mem_reg [tcktg_pkg::QUEUE_DEPTH];
    logic [PB-1:0]   wr_ptr_reg;
    logic [PB-1:0]   wr_ptr_next;
    logic [PB-1:0]   rd_ptr_reg;
    logic [PB-1:0]   rd_ptr_next;
    logic [PB:0]     count_reg;
    logic [PB:0]     count_next;

    assign full       = (count_reg == (PB+1)'(tcktg_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PB+1)'(push) - (PB+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[rtl/tcktg_back.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator back
// Executes queued commands: note and mute updates, and sample ticks through
// a phase stage, a sine table lookup and the output register.
// ----------------------------------------------------------------------------
module tcktg_back #(
    parameter int PHASE_BITS      = tcktg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = tcktg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = tcktg_pkg::SAMPLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  tcktg_pkg::cmd_t   head_cmd,
    output logic              pop,
    tcktg_audio_if.source     audio
);

    localparam int AB   = TABLE_ADDR_BITS;
    localparam int IB   = AB - 1;
    localparam int QLEN = 2 ** (AB - 2);
    localparam int OB   = tcktg_pkg::OUT_BITS;

    // Constant tables.
    logic [PHASE_BITS-1:0] step_one_tab [tcktg_pkg::NOTE_COUNT];
    logic [PHASE_BITS-1:0] step_two_tab [tcktg_pkg::NOTE_COUNT];
    logic [OB-1:0]         qrom [QLEN+1];

    for (genvar n = 0; n < tcktg_pkg::NOTE_COUNT; n++)
    begin : g_step
        localparam logic [63:0] S1 = tcktg_pkg::note_step(
            tcktg_pkg::note_tenths_one(tcktg_pkg::NOTE_BITS'(n)), PHASE_BITS);
        localparam logic [63:0] S2 = tcktg_pkg::note_step(
            tcktg_pkg::note_tenths_two(tcktg_pkg::NOTE_BITS'(n)), PHASE_BITS);
        assign step_one_tab[n] = S1[PHASE_BITS-1:0];
        assign step_two_tab[n] = S2[PHASE_BITS-1:0];
    end

    for (genvar j = 0; j <= QLEN; j++)
    begin : g_rom
        localparam logic [OB-1:0] M = tcktg_pkg::sine_mag(j, AB, SAMPLE_BITS);
        assign qrom[j] = M;
    end

    // Architectural state.
    logic [PHASE_BITS-1:0] step_one_reg;
    logic [PHASE_BITS-1:0] step_two_reg;
    logic [PHASE_BITS-1:0] phase_one_reg;
    logic [PHASE_BITS-1:0] phase_two_reg;
    logic                  mute_one_reg;
    logic                  mute_two_reg;
    logic [PHASE_BITS-1:0] step_one_next;
    logic [PHASE_BITS-1:0] step_two_next;
    logic [PHASE_BITS-1:0] phase_one_next;
    logic [PHASE_BITS-1:0] phase_two_next;
    logic                  mute_one_next;
    logic                  mute_two_next;

    // Lookup stage.
    logic                  a_valid_reg;
    logic                  a_valid_next;
    logic [IB-1:0]         a_idx_one_reg;
    logic [IB-1:0]         a_idx_two_reg;
    logic                  a_neg_one_reg;
    logic                  a_neg_two_reg;
    logic                  a_mute_one_reg;
    logic                  a_mute_two_reg;

    // Output stage.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OB-1:0]         left_reg;
    logic [OB-1:0]         right_reg;
    logic [OB-1:0]         left_next;
    logic [OB-1:0]         right_next;

    logic                  out_adv;
    logic                  a_ready;
    logic                  tick_pop;
    logic [AB-1:0]         addr_one;
    logic [AB-1:0]         addr_two;
    logic [IB-1:0]         idx_one;
    logic [IB-1:0]         idx_two;
    logic [OB-1:0]         mag_one;
    logic [OB-1:0]         mag_two;

    assign out_adv  = !out_valid_reg || audio.ready;
    assign a_ready  = !a_valid_reg || out_adv;
    assign pop      = head_valid && ((head_cmd.op != tcktg_pkg::OP_TICK) || a_ready);
    assign tick_pop = pop && (head_cmd.op == tcktg_pkg::OP_TICK);

    assign audio.valid        = out_valid_reg;
    assign audio.left_sample  = $signed(left_reg);
    assign audio.right_sample = $signed(right_reg);

    // Table address; odd quadrants read the quarter wave mirrored.
    assign addr_one = phase_one_reg[PHASE_BITS-1 -: AB];
    assign addr_two = phase_two_reg[PHASE_BITS-1 -: AB];
    assign idx_one  = addr_one[AB-2] ? IB'(QLEN) - {1'b0, addr_one[AB-3:0]}
                                     : {1'b0, addr_one[AB-3:0]};
    assign idx_two  = addr_two[AB-2] ? IB'(QLEN) - {1'b0, addr_two[AB-3:0]}
                                     : {1'b0, addr_two[AB-3:0]};

    assign mag_one  = qrom[a_idx_one_reg];
    assign mag_two  = qrom[a_idx_two_reg];

    always_comb
    begin
        step_one_next  = step_one_reg;
        step_two_next  = step_two_reg;
        phase_one_next = phase_one_reg;
        phase_two_next = phase_two_reg;
        mute_one_next  = mute_one_reg;
        mute_two_next  = mute_two_reg;
        if (pop)
        begin
            case (head_cmd.op)
                tcktg_pkg::OP_TICK:
                begin
                    phase_one_next = phase_one_reg + step_one_reg;
                    phase_two_next = phase_two_reg + step_two_reg;
                end
                tcktg_pkg::OP_NOTE_ONE: step_one_next = step_one_tab[head_cmd.note];
                tcktg_pkg::OP_NOTE_TWO: step_two_next = step_two_tab[head_cmd.note];
                tcktg_pkg::OP_MUTE_ONE: mute_one_next = !mute_one_reg;
                tcktg_pkg::OP_MUTE_TWO: mute_two_next = !mute_two_reg;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        a_valid_next   = a_ready ? tick_pop : a_valid_reg;
        out_valid_next = out_adv ? a_valid_reg : out_valid_reg;
        left_next      = a_neg_one_reg ? OB'(0) - mag_one : mag_one;
        right_next     = a_neg_two_reg ? OB'(0) - mag_two : mag_two;
        if (a_mute_one_reg)
        begin
            left_next = '0;
        end
        if (a_mute_two_reg)
        begin
            right_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_one_reg  <= '0;
            step_two_reg  <= '0;
            phase_one_reg <= '0;
            phase_two_reg <= '0;
            mute_one_reg  <= 1'b0;
            mute_two_reg  <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_one_reg  <= step_one_next;
            step_two_reg  <= step_two_next;
            phase_one_reg <= phase_one_next;
            phase_two_reg <= phase_two_next;
            mute_one_reg  <= mute_one_next;
            mute_two_reg  <= mute_two_next;
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_pop)
        begin
            a_idx_one_reg  <= idx_one;
            a_idx_two_reg  <= idx_two;
            a_neg_one_reg  <= addr_one[AB-1];
            a_neg_two_reg  <= addr_two[AB-1];
            a_mute_one_reg <= mute_one_reg;
            a_mute_two_reg <= mute_two_reg;
        end
        if (a_valid_reg && out_adv)
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

endmodule

[rtl/two_channel_key_tone_generator_top.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator
// Key-driven stereo sine synthesizer built on two phase accumulators.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the keys channel, ticks
// and key events alike, unless the front register and the queue are full,
// and a tick's stereo sample appears on the audio channel after it has
// passed the pipeline: the front register, the command queue, the phase
// and table-address stage and the output register. Key events for the
// notes a s d f q w e r set channel one (220 to 440 Hz), j k l ; u i o p set
// channel two (440 to 880 Hz), and v and n mute or unmute the two channels.
// Any other key code is dropped at the front and gives no result. Each tick
// returns the sine of the current phases, zero for a muted channel, and then
// advances both phases, so a note change never breaks the phase. After reset
// both channels are silent (step zero) and unmuted, and the first ticks give
// zero samples. A four-entry queue separates the front from the back, so a
// stalled audio sink does not stop key transactions until the queue fills.
// ----------------------------------------------------------------------------
module two_channel_key_tone_generator_top #(
    parameter int PHASE_BITS      = tcktg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = tcktg_pkg::TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = tcktg_pkg::SAMPLE_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    tcktg_key_if.sink     keys,
    tcktg_audio_if.source audio
);

    // Front to queue.
    logic            push;
    tcktg_pkg::cmd_t push_cmd;
    logic            q_full;

    // Queue to back.
    logic            head_valid;
    tcktg_pkg::cmd_t head_cmd;
    logic            pop;

    // The front classifies each transaction and keeps only those that matter.
    tcktg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .keys     (keys),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // Commands wait here in order while the back is stalled.
    tcktg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // The back owns the steps, phases and mute flags and makes the samples.
    tcktg_back #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .audio      (audio)
    );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Two-channel key tone generator testbench
// Sends key and tick transactions with bursty timing into the generator and
// checks every stereo sample against a cycle-free model of the synthesizer.
// The audio sink is throttled in several modes.
// ----------------------------------------------------------------------------
module testbench;

    import tcktg_pkg::*;

    // Kinds of transaction on the keys channel.
    typedef enum logic {
        ACT_KEY  = 1'b0,
        ACT_TICK = 1'b1
    } act_t;

    // Ways in which the audio sink throttles the output.
    typedef enum logic [1:0] {
        SINK_FREE  = 2'd0,
        SINK_COIN  = 2'd1,
        SINK_SLOW  = 2'd2,
        SINK_BURST = 2'd3
    } sink_mode_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] right;
    } tone_pair_t;

    // One row of the directed stimulus. When known is set, the sample pair
    // is typed in; otherwise the tone model supplies it.
    typedef struct {
        act_t                       act;
        logic [7:0]                 code;
        bit                         known;
        logic signed [OUT_BITS-1:0] left;
        logic signed [OUT_BITS-1:0] right;
    } stim_row_t;

    localparam int PHASE_W      = PHASE_BITS_DEF;
    localparam int ADDR_W       = TABLE_ADDR_BITS_DEF;
    localparam int QUARTER      = (2 ** ADDR_W) / 4;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DIRECTED_N   = 23;
    localparam int LIVE_N       = 18;

    localparam logic [7:0] LIVE_KEYS [LIVE_N] = '{
        KEY_A, KEY_S, KEY_D, KEY_F, KEY_Q, KEY_W, KEY_E, KEY_R,
        KEY_J, KEY_K, KEY_L, KEY_SEMI, KEY_U, KEY_I, KEY_O, KEY_P,
        KEY_V, KEY_N
    };

    logic clk;
    logic rst_n;

    tcktg_key_if   keys_ch ();
    tcktg_audio_if audio_ch ();

    two_channel_key_tone_generator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .keys  (keys_ch),
        .audio (audio_ch)
    );

    // ------------------------------------------------------------------------
    // Tone model state: phase steps, phase accumulators, mute flags and the
    // quarter-wave sine table, all at the widths of the block.
    // ------------------------------------------------------------------------
    logic [PHASE_W-1:0]  model_step_one;
    logic [PHASE_W-1:0]  model_step_two;
    logic [PHASE_W-1:0]  model_phase_one;
    logic [PHASE_W-1:0]  model_phase_two;
    logic                model_mute_one;
    logic                model_mute_two;
    logic [OUT_BITS-1:0] quarter_wave [0:QUARTER];

    // Stereo pairs that the block still owes, oldest first.
    tone_pair_t owed_pairs [$];

    int mismatch_count = 0;
    int burst_left     = 0;

    // Receiver throttling state.
    sink_mode_t sink_mode  = SINK_FREE;
    int         stall_left = 0;
    int         sink_cycle = 0;

    // Phase step of a note given in tenths of a hertz, rounded to nearest.
    function automatic logic [PHASE_W-1:0] tone_step(logic [15:0] tenths);
        logic [63:0] num;
        num = (64'(tenths) << PHASE_W) + 64'd220500;
        return PHASE_W'(num / 64'd441000);
    endfunction

    // One quarter-wave entry: angle in Q30, Taylor series to x^13 with each
    // term truncated, then scaled to the 16-bit full scale.
    function automatic logic [OUT_BITS-1:0] quarter_entry(int unsigned j);
        logic [63:0] ang;
        logic [63:0] ang_sq;
        logic [63:0] term;
        longint      acc;
        int unsigned n;
        ang    = (64'd1686629713 * 64'(j) + 64'(QUARTER / 2)) / 64'(QUARTER);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        for (n = 1; n <= 6; n++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        return OUT_BITS'((64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    // Sine sample at a phase, built from the quarter wave by mirroring the
    // odd quadrants and negating the second half of the period.
    function automatic logic signed [OUT_BITS-1:0] tone_sample(logic [PHASE_W-1:0] phase);
        logic [ADDR_W-1:0]   addr;
        logic [1:0]          quad;
        int                  offset;
        logic [OUT_BITS-1:0] mag;
        addr   = phase[PHASE_W-1 -: ADDR_W];
        quad   = addr[ADDR_W-1 -: 2];
        offset = int'(addr[ADDR_W-3:0]);
        mag    = quad[0] ? quarter_wave[QUARTER - offset] : quarter_wave[offset];
        if (quad[1])
        begin
            mag = -mag;
        end
        return mag;
    endfunction

    // Applies one accepted transaction to the tone model. A tick yields the
    // pair for the current phases and then advances both accumulators.
    task automatic advance_tone(input act_t act, input logic [7:0] code,
                                output bit has_pair, output tone_pair_t pair);
        has_pair = 1'b0;
        pair     = '0;
        if (act == ACT_TICK)
        begin
            has_pair        = 1'b1;
            pair.left       = model_mute_one ? '0 : tone_sample(model_phase_one);
            pair.right      = model_mute_two ? '0 : tone_sample(model_phase_two);
            model_phase_one = model_phase_one + model_step_one;
            model_phase_two = model_phase_two + model_step_two;
        end
        else
        begin
            case (code)
                KEY_A:    model_step_one = tone_step(16'd2200);
                KEY_S:    model_step_one = tone_step(16'd2469);
                KEY_D:    model_step_one = tone_step(16'd2772);
                KEY_F:    model_step_one = tone_step(16'd2937);
                KEY_Q:    model_step_one = tone_step(16'd3296);
                KEY_W:    model_step_one = tone_step(16'd3700);
                KEY_E:    model_step_one = tone_step(16'd4153);
                KEY_R:    model_step_one = tone_step(16'd4400);
                KEY_J:    model_step_two = tone_step(16'd4400);
                KEY_K:    model_step_two = tone_step(16'd4939);
                KEY_L:    model_step_two = tone_step(16'd5544);
                KEY_SEMI: model_step_two = tone_step(16'd5873);
                KEY_U:    model_step_two = tone_step(16'd6593);
                KEY_I:    model_step_two = tone_step(16'd7400);
                KEY_O:    model_step_two = tone_step(16'd8306);
                KEY_P:    model_step_two = tone_step(16'd8800);
                KEY_V:    model_mute_one = !model_mute_one;
                KEY_N:    model_mute_two = !model_mute_two;
                default:  ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d (pairs owed %0d)",
                 what, got, want, owed_pairs.size());
        mismatch_count++;
    endtask

    // Sends one transaction on the keys channel. The sender works in bursts:
    // when a burst is used up, valid drops for a random gap before the next
    // transaction. With hold set, the gap lasts until every owed pair has
    // come back. On acceptance the tone model is advanced and the pair,
    // typed in or modeled, is queued.
    task automatic send_tone_item(input act_t act, input logic [7:0] code, input bit hold,
                                  input bit known, input tone_pair_t known_pair);
        bit         has_pair;
        tone_pair_t pair;
        if (hold)
        begin
            keys_ch.valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (owed_pairs.size() != 0);
        end
        else if (burst_left <= 0)
        begin
            keys_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 30);
        end
        keys_ch.valid    <= 1'b1;
        keys_ch.action   <= act;
        keys_ch.key_code <= code;
        do
        begin
            @(posedge clk);
        end
        while (!keys_ch.ready);
        burst_left--;
        advance_tone(act, code, has_pair, pair);
        if (has_pair)
        begin
            owed_pairs.push_back(known ? known_pair : pair);
        end
    endtask

    // Directed rows: silence after reset, unlisted codes at both ends of the
    // byte range, the lowest and highest notes, both mutes together, and
    // notes changed in the middle of a tone.
    stim_row_t directed_rows [DIRECTED_N] = '{
        '{ACT_TICK, 8'h00,    1'b1, 16'sd0, 16'sd0},
        '{ACT_KEY,  8'h00,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  8'hFF,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'hFF,    1'b1, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_A,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b1, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_P,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'hAA,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_V,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_N,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h55,    1'b1, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_V,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_N,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_SEMI, 1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  KEY_R,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  8'h41,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b0, 16'sd0, 16'sd0},
        '{ACT_KEY,  8'h80,    1'b0, 16'sd0, 16'sd0},
        '{ACT_TICK, 8'h00,    1'b0, 16'sd0, 16'sd0}
    };

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // Audio sink. A new throttling mode is picked at regular intervals: always
    // ready, a coin toss per cycle, one cycle in four, or mostly ready with
    // occasional long stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 64 == 63)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
        end
        if (stall_left != 0)
        begin
            audio_ch.ready <= 1'b0;
            stall_left     <= stall_left - 1;
        end
        else
        begin
            case (sink_mode)
                SINK_FREE:  audio_ch.ready <= 1'b1;
                SINK_COIN:  audio_ch.ready <= 1'($urandom_range(0, 1));
                SINK_SLOW:  audio_ch.ready <= (sink_cycle % 4 == 0);
                SINK_BURST:
                begin
                    audio_ch.ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left <= $urandom_range(5, 30);
                    end
                end
                default:    audio_ch.ready <= 1'b1;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Sample checker. Each accepted audio transaction is compared, field by
    // field, with the oldest owed pair. A pair with nothing owed is a failure.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && audio_ch.valid && audio_ch.ready)
        begin
            if (owed_pairs.size() == 0)
            begin
                report_mismatch("unexpected sample pair, left", int'(audio_ch.left_sample), 0);
            end
            else
            begin
                if (audio_ch.left_sample !== owed_pairs[0].left)
                begin
                    report_mismatch("left_sample", int'(audio_ch.left_sample),
                                    int'(owed_pairs[0].left));
                end
                if (audio_ch.right_sample !== owed_pairs[0].right)
                begin
                    report_mismatch("right_sample", int'(audio_ch.right_sample),
                                    int'(owed_pairs[0].right));
                end
                void'(owed_pairs.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. It counts cycles in which no transaction is accepted on
    // either channel; the longest correct quiet spell is a sender gap plus a
    // sink stall plus the pipeline, far below the limit.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((keys_ch.valid && keys_ch.ready) || (audio_ch.valid && audio_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random traffic, then a
    // drain of the pipeline and the verdict.
    // ------------------------------------------------------------------------
    initial
    begin
        int         idx;
        int         pick;
        act_t       act;
        logic [7:0] code;
        tone_pair_t row_pair;

        // Every input of the block starts at a known value.
        rst_n            = 1'b0;
        keys_ch.valid    = 1'b0;
        keys_ch.action   = ACT_KEY;
        keys_ch.key_code = 8'h00;
        audio_ch.ready   = 1'b0;

        // The model starts in its reset state: silent, unmuted, phase zero.
        model_step_one  = '0;
        model_step_two  = '0;
        model_phase_one = '0;
        model_phase_two = '0;
        model_mute_one  = 1'b0;
        model_mute_two  = 1'b0;
        for (idx = 0; idx <= QUARTER; idx++)
        begin
            quarter_wave[idx] = quarter_entry(idx);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < DIRECTED_N; idx++)
        begin
            row_pair.left  = directed_rows[idx].left;
            row_pair.right = directed_rows[idx].right;
            send_tone_item(directed_rows[idx].act, directed_rows[idx].code, 1'b0,
                           directed_rows[idx].known, row_pair);
        end

        // Random traffic is mostly ticks and live keys, so tones change and
        // mutes toggle often, with a share of arbitrary codes as noise. The
        // key byte of a tick is random too. Twice the sender holds off until
        // the pipeline has returned every pair it owes.
        for (idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                act  = ACT_TICK;
                code = 8'($urandom_range(0, 255));
            end
            else if (pick < 85)
            begin
                act  = ACT_KEY;
                code = LIVE_KEYS[$urandom_range(0, LIVE_N - 1)];
            end
            else
            begin
                act  = ACT_KEY;
                code = 8'($urandom_range(0, 255));
            end
            send_tone_item(act, code, (idx == 250) || (idx == 500), 1'b0, '0);
        end
        keys_ch.valid <= 1'b0;

        // Wait for every owed pair, then let the pipeline settle.
        while (owed_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
